### rtl/core/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and constants of the quintic trajectory evaluator: fixed-point
// formats, pipeline depth, register indexes and the derivative weights.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

   // Fixed-point formats
   localparam int FRAC_W = 16;        // fraction bits of time and coefficients
   localparam int RES_W  = 32;        // result width, signed Q16.16
   localparam int LIMB_W = 32;        // operand slice of one partial product
   localparam int WGT_W  = 5;         // headroom for the largest weight (20)

   localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   // Pipeline shape: one multiply and one add stage per Horner step,
   // then the saturation stage that feeds the result channel
   localparam int NSTEP = 5;
   localparam int NSTG  = 2 * NSTEP + 1;
   localparam int T_STG = 2 * NSTEP - 2;

   // Coefficient registers
   localparam int NCOEF     = 6;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_DEG5 = CSR_IDX_W'(0),
      CSR_COEF_DEG4 = CSR_IDX_W'(1),
      CSR_COEF_DEG3 = CSR_IDX_W'(2),
      CSR_COEF_DEG2 = CSR_IDX_W'(3),
      CSR_COEF_DEG1 = CSR_IDX_W'(4),
      CSR_COEF_DEG0 = CSR_IDX_W'(5)
   } csr_index_type;

   // Load enables of the two registers of one Horner step
   typedef struct packed {
      logic mul_en;
      logic add_en;
   } stage_en_type;

   // First-derivative weight of a coefficient
   function automatic logic [WGT_W-1:0] vel_weight(input logic [CSR_IDX_W-1:0] idx);
      case (idx)
         CSR_COEF_DEG5: vel_weight = WGT_W'(5);
         CSR_COEF_DEG4: vel_weight = WGT_W'(4);
         CSR_COEF_DEG3: vel_weight = WGT_W'(3);
         CSR_COEF_DEG2: vel_weight = WGT_W'(2);
         CSR_COEF_DEG1: vel_weight = WGT_W'(1);
         default:       vel_weight = '0;
      endcase
   endfunction

   // Second-derivative weight of a coefficient
   function automatic logic [WGT_W-1:0] acc_weight(input logic [CSR_IDX_W-1:0] idx);
      case (idx)
         CSR_COEF_DEG5: acc_weight = WGT_W'(20);
         CSR_COEF_DEG4: acc_weight = WGT_W'(12);
         CSR_COEF_DEG3: acc_weight = WGT_W'(6);
         CSR_COEF_DEG2: acc_weight = WGT_W'(2);
         default:       acc_weight = '0;
      endcase
   endfunction

endpackage

`default_nettype wire

### rtl/core/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Channel interfaces of the evaluator: time samples in, motion results out,
// and the coefficient write port. Each carries valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

// Time sample channel
interface qte_req_if #(
   parameter int TIME_W = 24
);
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink   (input valid, input sample_time, output ready);
endinterface

// Result channel
interface qte_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qte_pkg::RES_W-1:0]   position;
   logic signed [qte_pkg::RES_W-1:0]   velocity;
   logic signed [qte_pkg::RES_W-1:0]   acceleration;
   logic                               saturated;

   modport source (output valid, output position, output velocity,
                   output acceleration, output saturated, input ready);
   modport sink   (input valid, input position, input velocity,
                   input acceleration, input saturated, output ready);
endinterface

// Coefficient write channel
interface qte_csr_if #(
   parameter int COEF_W = 32
);
   logic                          valid;
   logic                          ready;
   logic [qte_pkg::CSR_IDX_W-1:0] reg_index;
   logic [COEF_W-1:0]             wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### rtl/core/qte_mac.sv
// ----------------------------------------------------------------------------
// qte_mac
// One Horner step: step_acc = prev_acc * time + (coef << SHIFT) + RND, exact.
// Register 1 holds the limb-by-time partial products, register 2 the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_mac #(
   parameter int IN_W   = 37,
   parameter int OUT_W  = 62,
   parameter int TIME_W = 24,
   parameter int TERM_W = 37,
   parameter int SHIFT  = 16,
   parameter bit ROUND  = 1'b0
) (
   input  wire                         clock,
   input  wire qte_pkg::stage_en_type  en,
   input  wire  signed [IN_W-1:0]      prev_acc,
   input  wire         [TIME_W-1:0]    time_in,
   input  wire  signed [TERM_W-1:0]    term_coef,
   output logic signed [OUT_W-1:0]     step_acc
);

   localparam int LIMB_W  = qte_pkg::LIMB_W;
   localparam int NL      = (IN_W + LIMB_W - 1) / LIMB_W;
   localparam int EXT_W   = NL * LIMB_W;
   localparam int PP_W    = LIMB_W + TIME_W;
   localparam int SUM_W   = EXT_W + LIMB_W + OUT_W;
   localparam int TOP_OFF = (NL - 1) * LIMB_W;
   localparam int TOP_W   = SUM_W - TOP_OFF;
   localparam bit TOP_EVEN = ((NL - 1) % 2) == 0;
   localparam logic [SUM_W-1:0] RND = ROUND ? (SUM_W'(1) << (SHIFT - 1)) : '0;

   logic signed [EXT_W-1:0] acc_ext;
   logic [PP_W-1:0]         pp_in [NL];
   logic [PP_W-1:0]         pp_ff [NL];
   logic [TOP_W-1:0]        top_ext;
   logic [SUM_W-1:0]        even_vec;
   logic [SUM_W-1:0]        odd_vec;
   logic [SUM_W-1:0]        term_vec;
   logic [SUM_W-1:0]        sum_full;
   logic [OUT_W-1:0]        step_acc_in;
   logic [OUT_W-1:0]        step_acc_ff;

   assign acc_ext = EXT_W'(prev_acc);

   // Partial products; only the top limb carries the sign
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         if (l == NL - 1) begin
            pp_in[l] = PP_W'(signed'(acc_ext[l*LIMB_W +: LIMB_W]))
                       * signed'(PP_W'(time_in));
         end else begin
            pp_in[l] = PP_W'(acc_ext[l*LIMB_W +: LIMB_W]) * PP_W'(time_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         pp_ff <= pp_in;
      end
   end

   // Same-parity products sit 2 limbs apart and never overlap, so each
   // group is a plain concatenation and one add joins the two groups
   assign top_ext = TOP_W'(signed'(pp_ff[NL-1]));

   always_comb begin
      even_vec = '0;
      odd_vec  = '0;
      for (int l = 0; l < NL - 1; l += 2) begin
         even_vec[l*LIMB_W +: PP_W] = pp_ff[l];
      end
      for (int l = 1; l < NL - 1; l += 2) begin
         odd_vec[l*LIMB_W +: PP_W] = pp_ff[l];
      end
      if (TOP_EVEN) begin
         even_vec[TOP_OFF +: TOP_W] = top_ext;
      end else begin
         odd_vec[TOP_OFF +: TOP_W] = top_ext;
      end
   end

   // Coefficient term, with the rounding half-LSB on the last step
   assign term_vec    = (SUM_W'(term_coef) << SHIFT) | RND;
   assign sum_full    = even_vec + odd_vec + term_vec;
   assign step_acc_in = sum_full[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (en.add_en) begin
         step_acc_ff <= step_acc_in;
      end
   end

   assign step_acc = step_acc_ff;

endmodule

`default_nettype wire

### rtl/core/qte_sat.sv
// ----------------------------------------------------------------------------
// qte_sat
// Drops the fraction bits of an exact, already rounded accumulator and
// clamps it to signed Q16.16, flagging a clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sat #(
   parameter int IN_W  = 162,
   parameter int SHIFT = 80
) (
   input  wire  signed [IN_W-1:0]            value_in,
   output logic        [qte_pkg::RES_W-1:0]  value_out,
   output logic                              clamped
);

   localparam int RES_W = qte_pkg::RES_W;
   localparam int EXT_W = IN_W + RES_W + 1;

   logic signed [EXT_W-1:0]          value_ext;
   logic [EXT_W-SHIFT-RES_W:0]       upper;
   logic                             fits;

   assign value_ext = EXT_W'(value_in);

   // Fits when every bit from the result sign upward agrees
   assign upper   = value_ext[EXT_W-1:SHIFT+RES_W-1];
   assign fits    = (&upper) | ~(|upper);
   assign clamped = ~fits;

   always_comb begin
      if (fits) begin
         value_out = value_ext[SHIFT +: RES_W];
      end else if (value_ext[EXT_W-1]) begin
         value_out = qte_pkg::RES_MIN;
      end else begin
         value_out = qte_pkg::RES_MAX;
      end
   end

endmodule

`default_nettype wire

### rtl/core/quintic_trajectory_evaluator_top.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_top
// Position, velocity and acceleration of a quintic profile at a time sample,
// three Horner chains with exact wide accumulators, rounded and saturated.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    sample_time (unsigned Q8.16)
//   rsp_bus   out   valid/ready    position, velocity, acceleration, saturated
//   csr_bus   in    valid/ready    reg_index, wr_data (coefficients, Q16.16)
//
// One sample per cycle while req ready is high. Eleven register stages:
// five Horner steps of two stages each (partial products, then the add),
// then the saturation stage, whose register drives the result channel.
// Velocity and acceleration chains start one and two steps later so all
// three finish together. Reset clears the valid bits and the coefficients.
// Each stage holds only while the one after it is full and held, so bubbles
// close up; req ready drops only with all eleven stages occupied and rsp
// stalled. Coefficient writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_trajectory_evaluator_top #(
   parameter int COEF_WIDTH = 32,
   parameter int TIME_WIDTH = 24
) (
   input  wire          clock,
   input  wire          reset,
   qte_req_if.sink      req_bus,
   qte_rsp_if.source    rsp_bus,
   qte_csr_if.sink      csr_bus
);

   localparam int NSTEP  = qte_pkg::NSTEP;
   localparam int NSTG   = qte_pkg::NSTG;
   localparam int FRAC_W = qte_pkg::FRAC_W;
   localparam int RES_W  = qte_pkg::RES_W;
   localparam int WCW    = COEF_WIDTH + qte_pkg::WGT_W;
   localparam int G_W    = (TIME_WIDTH > FRAC_W) ? TIME_WIDTH : FRAC_W;
   localparam int STEP_G = G_W + 1;
   localparam int NVEL   = NSTEP - 1;
   localparam int NACC   = NSTEP - 2;
   localparam int WP     = WCW + NSTEP * STEP_G;
   localparam int WV     = WCW + NVEL * STEP_G;
   localparam int WA     = WCW + NACC * STEP_G;

   // ---------------------------------------------------------------------
   // Coefficient registers, stored pre-weighted for the derivative chains
   // ---------------------------------------------------------------------
   logic signed [WCW-1:0] pos_coef_ff [qte_pkg::NCOEF];
   logic signed [WCW-1:0] vel_coef_ff [NVEL + 1];
   logic signed [WCW-1:0] acc_coef_ff [NACC + 1];
   logic signed [WCW-1:0] csr_data_ext;
   logic                  csr_xfer;

   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid & csr_bus.ready;
   assign csr_data_ext  = WCW'(signed'(csr_bus.wr_data));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < qte_pkg::NCOEF; k++) pos_coef_ff[k] <= '0;
         for (int k = 0; k <= NVEL; k++) vel_coef_ff[k] <= '0;
         for (int k = 0; k <= NACC; k++) acc_coef_ff[k] <= '0;
      end else if (csr_xfer) begin
         if (csr_bus.reg_index inside {qte_pkg::CSR_COEF_DEG5, qte_pkg::CSR_COEF_DEG4,
                                       qte_pkg::CSR_COEF_DEG3, qte_pkg::CSR_COEF_DEG2,
                                       qte_pkg::CSR_COEF_DEG1, qte_pkg::CSR_COEF_DEG0}) begin
            pos_coef_ff[csr_bus.reg_index] <= csr_data_ext;
         end
         if (csr_bus.reg_index inside {qte_pkg::CSR_COEF_DEG5, qte_pkg::CSR_COEF_DEG4,
                                       qte_pkg::CSR_COEF_DEG3, qte_pkg::CSR_COEF_DEG2,
                                       qte_pkg::CSR_COEF_DEG1}) begin
            vel_coef_ff[csr_bus.reg_index] <= csr_data_ext
               * signed'({1'b0, qte_pkg::vel_weight(csr_bus.reg_index)});
         end
         if (csr_bus.reg_index inside {qte_pkg::CSR_COEF_DEG5, qte_pkg::CSR_COEF_DEG4,
                                       qte_pkg::CSR_COEF_DEG3, qte_pkg::CSR_COEF_DEG2}) begin
            acc_coef_ff[csr_bus.reg_index[1:0]] <= csr_data_ext
               * signed'({1'b0, qte_pkg::acc_weight(csr_bus.reg_index)});
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage control: valid bits and load enables
   // ---------------------------------------------------------------------
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] load;
   logic            in_xfer;
   logic            out_xfer;

   assign load[NSTG-1] = ~v_ff[NSTG-1] | rsp_bus.ready;
   for (genvar k = 0; k < NSTG - 1; k++) begin : g_load
      assign load[k] = ~v_ff[k] | load[k+1];
   end

   assign req_bus.ready = load[0];
   assign in_xfer       = req_bus.valid & req_bus.ready;
   assign out_xfer      = rsp_bus.valid & rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[0]) begin
            v_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Time sample travels with the item
   logic [TIME_WIDTH-1:0] t_ff [qte_pkg::T_STG];
   logic [TIME_WIDTH-1:0] t_src [1:NSTEP];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         t_ff[0] <= req_bus.sample_time;
      end
      for (int k = 1; k < qte_pkg::T_STG; k++) begin
         if (load[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
   end

   qte_pkg::stage_en_type step_en [1:NSTEP];

   assign t_src[1] = req_bus.sample_time;
   for (genvar p = 1; p <= NSTEP; p++) begin : g_step
      if (p > 1) begin : g_time
         assign t_src[p] = t_ff[2*p-3];
      end
      assign step_en[p].mul_en = load[2*p-2];
      assign step_en[p].add_en = load[2*p-1];
   end

   // ---------------------------------------------------------------------
   // Horner chains
   // ---------------------------------------------------------------------
   logic signed [WP-1:0] pos_acc [0:NSTEP];
   logic signed [WV-1:0] vel_acc [0:NVEL];
   logic signed [WA-1:0] acc_acc [0:NACC];

   assign pos_acc[0] = WP'(pos_coef_ff[0]);
   assign vel_acc[0] = WV'(vel_coef_ff[0]);
   assign acc_acc[0] = WA'(acc_coef_ff[0]);

   // Position: steps 1..5
   for (genvar j = 1; j <= NSTEP; j++) begin : g_pos
      localparam int IN_W = WCW + (j - 1) * STEP_G;
      logic signed [IN_W+STEP_G-1:0] out_acc;

      qte_mac #(
         .IN_W   (IN_W),
         .OUT_W  (IN_W + STEP_G),
         .TIME_W (TIME_WIDTH),
         .TERM_W (WCW),
         .SHIFT  (FRAC_W * j),
         .ROUND  (j == NSTEP)
      ) u_mac (
         .clock     (clock),
         .en        (step_en[j]),
         .prev_acc  (pos_acc[j-1][IN_W-1:0]),
         .time_in   (t_src[j]),
         .term_coef (pos_coef_ff[j]),
         .step_acc  (out_acc)
      );

      assign pos_acc[j] = WP'(out_acc);
   end

   // Velocity: one step behind position
   for (genvar j = 1; j <= NVEL; j++) begin : g_vel
      localparam int IN_W = WCW + (j - 1) * STEP_G;
      logic signed [IN_W+STEP_G-1:0] out_acc;

      qte_mac #(
         .IN_W   (IN_W),
         .OUT_W  (IN_W + STEP_G),
         .TIME_W (TIME_WIDTH),
         .TERM_W (WCW),
         .SHIFT  (FRAC_W * j),
         .ROUND  (j == NVEL)
      ) u_mac (
         .clock     (clock),
         .en        (step_en[j+1]),
         .prev_acc  (vel_acc[j-1][IN_W-1:0]),
         .time_in   (t_src[j+1]),
         .term_coef (vel_coef_ff[j]),
         .step_acc  (out_acc)
      );

      assign vel_acc[j] = WV'(out_acc);
   end

   // Acceleration: two steps behind position
   for (genvar j = 1; j <= NACC; j++) begin : g_acc
      localparam int IN_W = WCW + (j - 1) * STEP_G;
      logic signed [IN_W+STEP_G-1:0] out_acc;

      qte_mac #(
         .IN_W   (IN_W),
         .OUT_W  (IN_W + STEP_G),
         .TIME_W (TIME_WIDTH),
         .TERM_W (WCW),
         .SHIFT  (FRAC_W * j),
         .ROUND  (j == NACC)
      ) u_mac (
         .clock     (clock),
         .en        (step_en[j+2]),
         .prev_acc  (acc_acc[j-1][IN_W-1:0]),
         .time_in   (t_src[j+2]),
         .term_coef (acc_coef_ff[j]),
         .step_acc  (out_acc)
      );

      assign acc_acc[j] = WA'(out_acc);
   end

   // ---------------------------------------------------------------------
   // Saturation and result register
   // ---------------------------------------------------------------------
   logic [RES_W-1:0] pos_res_in;
   logic [RES_W-1:0] vel_res_in;
   logic [RES_W-1:0] accel_res_in;
   logic             pos_clamp;
   logic             vel_clamp;
   logic             accel_clamp;
   logic [RES_W-1:0] pos_res_ff;
   logic [RES_W-1:0] vel_res_ff;
   logic [RES_W-1:0] accel_res_ff;
   logic             sat_ff;

   qte_sat #(.IN_W(WP), .SHIFT(FRAC_W * NSTEP)) u_sat_pos (
      .value_in  (pos_acc[NSTEP]),
      .value_out (pos_res_in),
      .clamped   (pos_clamp)
   );

   qte_sat #(.IN_W(WV), .SHIFT(FRAC_W * NVEL)) u_sat_vel (
      .value_in  (vel_acc[NVEL]),
      .value_out (vel_res_in),
      .clamped   (vel_clamp)
   );

   qte_sat #(.IN_W(WA), .SHIFT(FRAC_W * NACC)) u_sat_acc (
      .value_in  (acc_acc[NACC]),
      .value_out (accel_res_in),
      .clamped   (accel_clamp)
   );

   always_ff @(posedge clock) begin
      if (load[NSTG-1]) begin
         pos_res_ff   <= pos_res_in;
         vel_res_ff   <= vel_res_in;
         accel_res_ff <= accel_res_in;
         sat_ff       <= pos_clamp | vel_clamp | accel_clamp;
      end
   end

   assign rsp_bus.valid        = v_ff[NSTG-1];
   assign rsp_bus.position     = pos_res_ff;
   assign rsp_bus.velocity     = vel_res_ff;
   assign rsp_bus.acceleration = accel_res_ff;
   assign rsp_bus.saturated    = sat_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // Input is refused only when every stage holds an item
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&v_ff))
      else $error("req ready low with an empty stage");

   // Items in flight change only by transfers on the two channels
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(v_ff) ==
         $past($countones(v_ff)) + int'($past(in_xfer)) - int'($past(out_xfer)))
      else $error("item lost or duplicated in pipeline");

   // A clamp flag comes with at least one clamped value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |->
         (pos_res_ff == qte_pkg::RES_MAX || pos_res_ff == qte_pkg::RES_MIN ||
          vel_res_ff == qte_pkg::RES_MAX || vel_res_ff == qte_pkg::RES_MIN ||
          accel_res_ff == qte_pkg::RES_MAX || accel_res_ff == qte_pkg::RES_MIN))
      else $error("saturated flag without a clamped output");

endmodule

`default_nettype wire
